>>> src/assert_macros.svh
// Assertion helpers used by complex_fir_filter_unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> src/cfir_pkg.sv
package cfir_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int MAX_TAPS     = 32;
    localparam int CNT_W        = $clog2(MAX_TAPS);
    localparam int TAP_IDX_W    = 5;
    localparam int TAP_COUNT_W  = 6;
    localparam int SCALE_W      = 16;
    localparam int SCALE_FRAC   = 12;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 1;

    localparam int PROD_W    = 2 * SAMPLE_WIDTH;
    localparam int ACC_W     = PROD_W + 1 + CNT_W;
    localparam int SCALED_W  = ACC_W + SCALE_W;
    localparam int OUT_SHIFT = (SAMPLE_WIDTH - 1) + SCALE_FRAC;
    localparam int CMP_W     = (CNT_W > TAP_COUNT_W) ? CNT_W : TAP_COUNT_W;
    localparam int IDX_CMP_W = (CNT_W > TAP_IDX_W) ? CNT_W : TAP_IDX_W;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_COEF   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 1'b1;

    localparam logic [TAP_COUNT_W-1:0]    TAP_COUNT_RESET = 6'd1;
    localparam logic signed [SCALE_W-1:0] SCALE_RESET     = 16'sd4096;

    localparam logic signed [SCALED_W-1:0] ROUND_HALF =
        {{(SCALED_W - OUT_SHIFT){1'b0}}, 1'b1, {(OUT_SHIFT - 1){1'b0}}};
    localparam logic signed [SCALED_W-1:0] SAT_HI =
        {{(SCALED_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic signed [SCALED_W-1:0] SAT_LO =
        {{(SCALED_W - SAMPLE_WIDTH + 1){1'b1}}, {(SAMPLE_WIDTH - 1){1'b0}}};

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] re;
        logic signed [SAMPLE_WIDTH-1:0] im;
    } cplx_t;

    typedef struct packed {
        logic shift;
        logic rotate;
        logic coef_we;
    } cell_ctl_t;

    typedef struct packed {
        logic clear;
        logic prod_en;
        logic scale_en;
    } mac_ctl_t;

    // Round half up, drop the fraction, saturate: returns {clip, value}.
    function automatic logic [SAMPLE_WIDTH:0] finish_part(
        input logic signed [SCALED_W-1:0] p
    );
        logic signed [SCALED_W-1:0] r;
        logic signed [SCALED_W-1:0] v;
        logic [SAMPLE_WIDTH:0]      res;
        r = p + ROUND_HALF;
        v = r >>> OUT_SHIFT;
        if (v > SAT_HI) begin
            res = {1'b1, SAT_HI[SAMPLE_WIDTH-1:0]};
        end else if (v < SAT_LO) begin
            res = {1'b1, SAT_LO[SAMPLE_WIDTH-1:0]};
        end else begin
            res = {1'b0, v[SAMPLE_WIDTH-1:0]};
        end
        return res;
    endfunction

endpackage

>>> src/complex_fir_filter_unit.sv
// Sample request: once accepted, the MAX_TAPS-step rotation of the cell chain
// through the single complex multiply-accumulate at its head, then scaling; no
// new request is taken until the result is loaded into the output register.
// Coefficient request: written into the addressed tap when taken, no result.
// Reset (aresetn, synchronous, active low) zeroes the delay line, the step
// counter and control; tap_count returns to 1, scale to 1.0; taps stay unset.
`include "assert_macros.svh"

module complex_fir_filter_unit (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      cfg_we,
    input  logic [cfir_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [cfir_pkg::CFG_DATA_W-1:0]           cfg_data,
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  logic                                      s_cmd,
    input  logic [cfir_pkg::TAP_IDX_W-1:0]            s_tap_index,
    input  logic signed [cfir_pkg::SAMPLE_WIDTH-1:0]  s_coef_re,
    input  logic signed [cfir_pkg::SAMPLE_WIDTH-1:0]  s_coef_im,
    input  logic signed [cfir_pkg::SAMPLE_WIDTH-1:0]  s_sample_re,
    input  logic signed [cfir_pkg::SAMPLE_WIDTH-1:0]  s_sample_im,
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic signed [cfir_pkg::SAMPLE_WIDTH-1:0]  m_out_re,
    output logic signed [cfir_pkg::SAMPLE_WIDTH-1:0]  m_out_im,
    output logic                                      m_saturated
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_RUN   = 5'b00010,
        ST_ACC   = 5'b00100,
        ST_SCALE = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t                                   state_reg, state_next;
    logic [cfir_pkg::CNT_W-1:0]               cnt_reg, cnt_next;
    logic [cfir_pkg::TAP_COUNT_W-1:0]         tap_count_reg, tap_count_next;
    logic signed [cfir_pkg::SCALE_W-1:0]      scale_reg, scale_next;
    logic                                     m_valid_reg, m_valid_next;
    logic signed [cfir_pkg::SAMPLE_WIDTH-1:0] out_re_reg, out_re_next;
    logic signed [cfir_pkg::SAMPLE_WIDTH-1:0] out_im_reg, out_im_next;
    logic                                     sat_reg, sat_next;

    logic               s_acc;
    logic               out_load;
    logic               tap_used;
    logic               last_step;
    cfir_pkg::cell_ctl_t cell_ctl;
    cfir_pkg::mac_ctl_t  mac_ctl;
    cfir_pkg::cplx_t     new_sample;
    cfir_pkg::cplx_t     new_coef;
    cfir_pkg::cplx_t     x_q [cfir_pkg::MAX_TAPS];
    cfir_pkg::cplx_t     h_q [cfir_pkg::MAX_TAPS];
    logic               mac_prod_vld;
    logic signed [cfir_pkg::SAMPLE_WIDTH-1:0] mac_re, mac_im;
    logic               mac_sat;

    // Configuration registers.
    always_comb begin
        tap_count_next = tap_count_reg;
        scale_next     = scale_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                cfir_pkg::CFG_TAP_COUNT: begin
                    tap_count_next = cfg_data[cfir_pkg::TAP_COUNT_W-1:0];
                end
                cfir_pkg::CFG_SCALE: begin
                    scale_next = cfg_data[cfir_pkg::SCALE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_count_reg <= cfir_pkg::TAP_COUNT_RESET;
            scale_reg     <= cfir_pkg::SCALE_RESET;
        end else begin
            tap_count_reg <= tap_count_next;
            scale_reg     <= scale_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign s_acc   = s_valid && s_ready;

    // Tap count zero still uses tap 0; counts past the chain length clamp by
    // themselves since the step never reaches MAX_TAPS.
    assign tap_used = (cnt_reg == '0) ||
        (cfir_pkg::CMP_W'(cnt_reg) < cfir_pkg::CMP_W'(tap_count_reg));
    assign last_step = (cnt_reg == cfir_pkg::CNT_W'(cfir_pkg::MAX_TAPS - 1));
    assign out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc && (s_cmd == cfir_pkg::CMD_SAMPLE)) begin
                    state_next = ST_RUN;
                    cnt_next   = '0;
                end
            end
            ST_RUN: begin
                cnt_next = cnt_reg + 1'b1;
                if (last_step) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign cell_ctl.shift    = s_acc && (s_cmd == cfir_pkg::CMD_SAMPLE);
    assign cell_ctl.coef_we  = s_acc && (s_cmd == cfir_pkg::CMD_COEF);
    assign cell_ctl.rotate   = (state_reg == ST_RUN);

    assign mac_ctl.clear     = cell_ctl.shift;
    assign mac_ctl.prod_en   = (state_reg == ST_RUN) && tap_used;
    assign mac_ctl.scale_en  = (state_reg == ST_SCALE);

    assign new_sample.re = s_sample_re;
    assign new_sample.im = s_sample_im;
    assign new_coef.re   = s_coef_re;
    assign new_coef.im   = s_coef_im;

    // Shift moves samples away from cell 0; rotation walks the pairs toward
    // cell 0 and wraps, so after MAX_TAPS steps the chain is home again.
    for (genvar k = 0; k < cfir_pkg::MAX_TAPS; k++) begin : g_cell
        logic coef_sel;
        assign coef_sel = (cfir_pkg::IDX_CMP_W'(s_tap_index) == cfir_pkg::IDX_CMP_W'(k));

        cfir_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (cell_ctl),
            .coef_sel (coef_sel),
            .shift_in ((k == 0) ? new_sample : x_q[(k + cfir_pkg::MAX_TAPS - 1)
                                                    % cfir_pkg::MAX_TAPS]),
            .rot_x_in (x_q[(k + 1) % cfir_pkg::MAX_TAPS]),
            .rot_h_in (h_q[(k + 1) % cfir_pkg::MAX_TAPS]),
            .coef_in  (new_coef),
            .x_out    (x_q[k]),
            .h_out    (h_q[k])
        );
    end

    cfir_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (mac_ctl),
        .h        (h_q[0]),
        .x        (x_q[0]),
        .scale    (scale_reg),
        .prod_vld (mac_prod_vld),
        .res_re   (mac_re),
        .res_im   (mac_im),
        .res_sat  (mac_sat)
    );

    // Output register: hold the result until taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        out_re_next  = out_re_reg;
        out_im_next  = out_im_reg;
        sat_next     = sat_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            out_re_next  = mac_re;
            out_im_next  = mac_im;
            sat_next     = mac_sat;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_re_reg <= out_re_next;
        out_im_reg <= out_im_next;
        sat_reg    <= sat_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_out_re    = out_re_reg;
    assign m_out_im    = out_im_reg;
    assign m_saturated = sat_reg;

    `ASSERT_NEXT(a_sample_starts_run, aclk, aresetn, cell_ctl.shift, (state_reg == ST_RUN) && (cnt_reg == '0))
    `ASSERT_SAME(a_no_product_when_idle, aclk, aresetn, state_reg == ST_IDLE, !mac_prod_vld)
    `ASSERT_NEXT(a_load_shows_result, aclk, aresetn, out_load, m_valid && (state_reg == ST_IDLE))
    `ASSERT_SAME(a_sat_at_rail, aclk, aresetn, m_valid && m_saturated, (m_out_re == cfir_pkg::SAT_HI[cfir_pkg::SAMPLE_WIDTH-1:0]) || (m_out_re == cfir_pkg::SAT_LO[cfir_pkg::SAMPLE_WIDTH-1:0]) || (m_out_im == cfir_pkg::SAT_HI[cfir_pkg::SAMPLE_WIDTH-1:0]) || (m_out_im == cfir_pkg::SAT_LO[cfir_pkg::SAMPLE_WIDTH-1:0]))

endmodule

>>> src/cfir_cell.sv
module cfir_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfir_pkg::cell_ctl_t ctl,
    input  logic                coef_sel,
    input  cfir_pkg::cplx_t     shift_in,
    input  cfir_pkg::cplx_t     rot_x_in,
    input  cfir_pkg::cplx_t     rot_h_in,
    input  cfir_pkg::cplx_t     coef_in,
    output cfir_pkg::cplx_t     x_out,
    output cfir_pkg::cplx_t     h_out
);

    cfir_pkg::cplx_t x_reg, x_next;
    cfir_pkg::cplx_t h_reg, h_next;

    always_comb begin
        x_next = x_reg;
        if (ctl.shift) begin
            x_next = shift_in;
        end else if (ctl.rotate) begin
            x_next = rot_x_in;
        end
    end

    always_comb begin
        h_next = h_reg;
        if (ctl.coef_we && coef_sel) begin
            h_next = coef_in;
        end else if (ctl.rotate) begin
            h_next = rot_h_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg <= '0;
        end else begin
            x_reg <= x_next;
        end
    end

    // Taps hold garbage until written.
    always_ff @(posedge aclk) begin
        h_reg <= h_next;
    end

    assign x_out = x_reg;
    assign h_out = h_reg;

endmodule

>>> src/cfir_mac.sv
module cfir_mac (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  cfir_pkg::mac_ctl_t                    ctl,
    input  cfir_pkg::cplx_t                       h,
    input  cfir_pkg::cplx_t                       x,
    input  logic signed [cfir_pkg::SCALE_W-1:0]   scale,
    output logic                                  prod_vld,
    output logic signed [cfir_pkg::SAMPLE_WIDTH-1:0] res_re,
    output logic signed [cfir_pkg::SAMPLE_WIDTH-1:0] res_im,
    output logic                                  res_sat
);

    logic signed [cfir_pkg::PROD_W-1:0]   p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [cfir_pkg::PROD_W-1:0]   p_rr_next, p_ii_next, p_ri_next, p_ir_next;
    logic                                 prod_vld_reg;
    logic signed [cfir_pkg::ACC_W-1:0]    acc_re_reg, acc_im_reg;
    logic signed [cfir_pkg::ACC_W-1:0]    acc_re_next, acc_im_next;
    logic signed [cfir_pkg::SCALED_W-1:0] sc_re_reg, sc_im_reg;
    logic signed [cfir_pkg::SCALED_W-1:0] sc_re_next, sc_im_next;
    logic [cfir_pkg::SAMPLE_WIDTH:0]      fin_re, fin_im;

    assign p_rr_next = cfir_pkg::PROD_W'(h.re) * cfir_pkg::PROD_W'(x.re);
    assign p_ii_next = cfir_pkg::PROD_W'(h.im) * cfir_pkg::PROD_W'(x.im);
    assign p_ri_next = cfir_pkg::PROD_W'(h.re) * cfir_pkg::PROD_W'(x.im);
    assign p_ir_next = cfir_pkg::PROD_W'(h.im) * cfir_pkg::PROD_W'(x.re);

    always_ff @(posedge aclk) begin
        p_rr_reg <= p_rr_next;
        p_ii_reg <= p_ii_next;
        p_ri_reg <= p_ri_next;
        p_ir_reg <= p_ir_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= ctl.prod_en;
        end
    end

    always_comb begin
        acc_re_next = acc_re_reg;
        acc_im_next = acc_im_reg;
        if (ctl.clear) begin
            acc_re_next = '0;
            acc_im_next = '0;
        end else if (prod_vld_reg) begin
            acc_re_next = acc_re_reg + cfir_pkg::ACC_W'(p_rr_reg)
                                     - cfir_pkg::ACC_W'(p_ii_reg);
            acc_im_next = acc_im_reg + cfir_pkg::ACC_W'(p_ri_reg)
                                     + cfir_pkg::ACC_W'(p_ir_reg);
        end
    end

    always_ff @(posedge aclk) begin
        acc_re_reg <= acc_re_next;
        acc_im_reg <= acc_im_next;
    end

    always_comb begin
        sc_re_next = sc_re_reg;
        sc_im_next = sc_im_reg;
        if (ctl.scale_en) begin
            sc_re_next = cfir_pkg::SCALED_W'(acc_re_reg) * cfir_pkg::SCALED_W'(scale);
            sc_im_next = cfir_pkg::SCALED_W'(acc_im_reg) * cfir_pkg::SCALED_W'(scale);
        end
    end

    always_ff @(posedge aclk) begin
        sc_re_reg <= sc_re_next;
        sc_im_reg <= sc_im_next;
    end

    assign fin_re   = cfir_pkg::finish_part(sc_re_reg);
    assign fin_im   = cfir_pkg::finish_part(sc_im_reg);
    assign res_re   = fin_re[cfir_pkg::SAMPLE_WIDTH-1:0];
    assign res_im   = fin_im[cfir_pkg::SAMPLE_WIDTH-1:0];
    assign res_sat  = fin_re[cfir_pkg::SAMPLE_WIDTH] | fin_im[cfir_pkg::SAMPLE_WIDTH];
    assign prod_vld = prod_vld_reg;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import cfir_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RAND_PHASES  = 12;
    localparam int PHASE_ITEMS  = 125;

    typedef logic signed [SAMPLE_WIDTH-1:0] smp_t;

    localparam smp_t   SMP_MAX = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam smp_t   SMP_MIN = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};
    localparam longint OUT_MAX = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
    localparam longint OUT_MIN = -OUT_MAX - 1;

    typedef struct {
        logic                 cmd;
        logic [TAP_IDX_W-1:0] tap;
        smp_t                 coef_re;
        smp_t                 coef_im;
        smp_t                 smp_re;
        smp_t                 smp_im;
    } fir_req_t;

    typedef struct {
        smp_t re;
        smp_t im;
        logic sat;
    } fir_out_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic                  s_cmd       = CMD_SAMPLE;
    logic [TAP_IDX_W-1:0]  s_tap_index = '0;
    smp_t                  s_coef_re   = '0;
    smp_t                  s_coef_im   = '0;
    smp_t                  s_sample_re = '0;
    smp_t                  s_sample_im = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    smp_t                  m_out_re;
    smp_t                  m_out_im;
    logic                  m_saturated;

    // filter state as seen by the predictor
    smp_t                      tap_re  [MAX_TAPS];
    smp_t                      tap_im  [MAX_TAPS];
    bit                        tap_set [MAX_TAPS];
    smp_t                      line_re [MAX_TAPS];
    smp_t                      line_im [MAX_TAPS];
    int                        wr_pos;
    logic [TAP_COUNT_W-1:0]    taps_cfg;
    logic signed [SCALE_W-1:0] gain;

    // taps already queued for writing, tracked on the stimulus side
    bit gen_set [MAX_TAPS];

    fir_req_t req_q[$];
    fir_out_t filt_q[$];
    fir_req_t nxt;
    int       err_cnt    = 0;
    int       cycle_cnt  = 0;
    int       gap_left   = 0;
    int       stall_left = 0;
    bit       req_taken  = 1'b0;
    bit       send_idle  = 1'b1;
    bit       recv_stall = 1'b1;

    complex_fir_filter_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_tap_index (s_tap_index),
        .s_coef_re   (s_coef_re),
        .s_coef_im   (s_coef_im),
        .s_sample_re (s_sample_re),
        .s_sample_im (s_sample_im),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_re    (m_out_re),
        .m_out_im    (m_out_im),
        .m_saturated (m_saturated)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(8, 40);
    endfunction

    function automatic smp_t pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return SMP_MIN;
        if (r < 16) return SMP_MAX;
        if (r < 20) return '0;
        return smp_t'($urandom);
    endfunction

    function automatic longint scale_round(input longint acc);
        longint p;
        p = acc * longint'(gain) + (longint'(1) << (OUT_SHIFT - 1));
        return p >>> OUT_SHIFT;
    endfunction

    function automatic longint clamp(input longint v);
        if (v > OUT_MAX) return OUT_MAX;
        if (v < OUT_MIN) return OUT_MIN;
        return v;
    endfunction

    task automatic filter_request();
        longint   acc_re;
        longint   acc_im;
        longint   v_re;
        longint   v_im;
        longint   hr;
        longint   hi;
        longint   xr;
        longint   xi;
        int       n;
        int       pos;
        fir_out_t o;
        if (s_cmd == CMD_COEF) begin
            tap_re[s_tap_index]  = s_coef_re;
            tap_im[s_tap_index]  = s_coef_im;
            tap_set[s_tap_index] = 1'b1;
        end else begin
            line_re[wr_pos] = s_sample_re;
            line_im[wr_pos] = s_sample_im;
            n = int'(taps_cfg);
            if (n == 0) n = 1;
            if (n > MAX_TAPS) n = MAX_TAPS;
            acc_re = 0;
            acc_im = 0;
            for (int k = 0; k < n; k++) begin
                if (tap_set[k]) begin
                    pos = (wr_pos + MAX_TAPS - k) % MAX_TAPS;
                    hr = longint'(tap_re[k]);
                    hi = longint'(tap_im[k]);
                    xr = longint'(line_re[pos]);
                    xi = longint'(line_im[pos]);
                    acc_re += hr * xr - hi * xi;
                    acc_im += hr * xi + hi * xr;
                end
            end
            wr_pos = (wr_pos + 1) % MAX_TAPS;
            v_re  = scale_round(acc_re);
            v_im  = scale_round(acc_im);
            o.re  = smp_t'(clamp(v_re));
            o.im  = smp_t'(clamp(v_im));
            o.sat = (clamp(v_re) != v_re) || (clamp(v_im) != v_im);
            filt_q.push_back(o);
        end
    endtask

    task automatic check_result();
        fir_out_t e;
        if (filt_q.size() == 0) begin
            $display("%0t: unexpected result re %0d im %0d saturated %0d", $time,
                     m_out_re, m_out_im, m_saturated);
            err_cnt++;
        end else begin
            e = filt_q.pop_front();
            if (m_out_re !== e.re) begin
                $display("%0t: out_re expected %0d, got %0d", $time, e.re, m_out_re);
                err_cnt++;
            end
            if (m_out_im !== e.im) begin
                $display("%0t: out_im expected %0d, got %0d", $time, e.im, m_out_im);
                err_cnt++;
            end
            if (m_saturated !== e.sat) begin
                $display("%0t: saturated expected %0d, got %0d", $time, e.sat,
                         m_saturated);
                err_cnt++;
            end
        end
    endtask

    always @(posedge aclk) begin
        cycle_cnt = cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            req_taken <= s_valid && s_ready;
            if (aresetn && s_valid && s_ready) filter_request();
            if (aresetn && m_valid && m_ready) check_result();
        end
    end

    // request driver: hold until taken, then idle or present the next one
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || req_taken) begin
            if (gap_left != 0) begin
                gap_left = gap_left - 1;
                s_valid <= 1'b0;
            end else if (req_q.size() != 0) begin
                nxt = req_q.pop_front();
                s_cmd       <= nxt.cmd;
                s_tap_index <= nxt.tap;
                s_coef_re   <= nxt.coef_re;
                s_coef_im   <= nxt.coef_im;
                s_sample_re <= nxt.smp_re;
                s_sample_im <= nxt.smp_im;
                s_valid     <= 1'b1;
                gap_left = send_idle ? idle_len() : 0;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn || !recv_stall) begin
            m_ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left = stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            stall_left = idle_len();
        end
    end

    task automatic push_coef(input int k, input smp_t re, input smp_t im);
        fir_req_t r;
        r.cmd     = CMD_COEF;
        r.tap     = k[TAP_IDX_W-1:0];
        r.coef_re = re;
        r.coef_im = im;
        r.smp_re  = smp_t'($urandom);
        r.smp_im  = smp_t'($urandom);
        gen_set[k] = 1'b1;
        req_q.push_back(r);
    endtask

    task automatic push_sample(input smp_t re, input smp_t im);
        fir_req_t r;
        r.cmd     = CMD_SAMPLE;
        r.tap     = TAP_IDX_W'($urandom);
        r.coef_re = smp_t'($urandom);
        r.coef_im = smp_t'($urandom);
        r.smp_re  = re;
        r.smp_im  = im;
        req_q.push_back(r);
    endtask

    // wait until every request is taken and every result is back, then drain
    task automatic settle();
        while (req_q.size() != 0 || s_valid || filt_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [TAP_COUNT_W-1:0] tc,
                             input logic signed [SCALE_W-1:0] sc);
        logic [CFG_DATA_W-1:0] d;
        d = CFG_DATA_W'($urandom);
        d[TAP_COUNT_W-1:0] = tc;
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TAP_COUNT;
        cfg_data  <= d;
        @(negedge aclk);
        cfg_index <= CFG_SCALE;
        cfg_data  <= sc;
        @(negedge aclk);
        cfg_we <= 1'b0;
        taps_cfg = tc;
        gain     = sc;
    endtask

    initial begin
        logic [TAP_COUNT_W-1:0]    tc;
        logic signed [SCALE_W-1:0] sc;
        int                        eff;
        for (int k = 0; k < MAX_TAPS; k++) begin
            tap_set[k] = 1'b0;
            gen_set[k] = 1'b0;
            line_re[k] = '0;
            line_im[k] = '0;
        end
        wr_pos   = 0;
        taps_cfg = TAP_COUNT_RESET;
        gain     = SCALE_RESET;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: single tap, unity gain
        push_coef(0, SMP_MAX, '0);
        push_sample(SMP_MAX, SMP_MIN);
        push_sample(SMP_MIN, SMP_MAX);
        push_sample('0, '0);
        push_coef(0, SMP_MIN, '0);
        push_sample(SMP_MIN, SMP_MIN);
        push_sample(SMP_MAX, SMP_MAX);
        push_coef(0, SMP_MIN, SMP_MIN);
        push_sample(SMP_MIN, SMP_MIN);
        push_sample(SMP_MAX, SMP_MIN);
        push_sample(SMP_MIN, SMP_MAX);

        for (int ph = 1; ph <= RAND_PHASES; ph++) begin
            settle();
            case (ph)
                1: begin tc = 1;  sc = SMP_MAX; end
                2: begin tc = 32; sc = 4096;    end
                3: begin tc = 0;  sc = SMP_MIN; end
                4: begin tc = 63; sc = 1;       end
                5: begin tc = 2;  sc = 0;       end
                6: begin tc = 32; sc = SMP_MAX; end
                7: begin tc = 5;  sc = -4096;   end
                default: begin
                    tc = TAP_COUNT_W'($urandom_range(0, 63));
                    sc = SCALE_W'($urandom);
                end
            endcase
            write_cfg(tc, sc);
            send_idle  = (ph % 3 != 1);
            recv_stall = (ph % 4 != 2);

            // load every active tap before any sample reads it
            eff = (tc == 0) ? 1 : (tc > MAX_TAPS) ? MAX_TAPS : int'(tc);
            for (int k = 0; k < eff; k++) begin
                if (!gen_set[k]) push_coef(k, pick_value(), pick_value());
            end
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 15)
                    push_coef($urandom_range(0, MAX_TAPS - 1), pick_value(), pick_value());
                else
                    push_sample(pick_value(), pick_value());
            end
        end

        settle();
        if (err_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
